### design/cdslc_pkg.sv
// Shared types, codes and constants for the coil drive status LED colorizer.
`timescale 1ns / 1ps
`default_nettype none
package cdslc_pkg;

  localparam int LED_COUNT_DEF = 4;
  localparam int LED_COUNT_MAX = 4;

  localparam int CMD_W     = 16;
  localparam int FS_W      = 15;
  localparam int MAP_W     = 8;
  localparam int PHASE_W   = 16;
  localparam int LED_W     = 2;
  localparam int COLOR_W   = 8;
  localparam int GREEN_W   = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam int QUO_W   = 8;
  localparam int STEP_W  = 3;
  localparam int NUM_W   = 23;
  localparam int DSH_W   = FS_W + QUO_W - 1;

  localparam logic [COLOR_W-1:0] BRIGHT_CAP = 8'd160;
  localparam logic [GREEN_W-1:0] GREEN_BASE = 7'd16;
  localparam logic [COLOR_W-1:0] CHASE_DIM  = 8'd12;
  localparam logic [FS_W-1:0]    IDLE_DEN   = 15'd255;

  localparam logic [MAP_W-1:0] MAP_RESET = 8'd228;
  localparam logic [FS_W-1:0]  FS_RESET  = 15'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_LED_MAP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 8'd1;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_FAULT = 2'd1,
    MODE_BOOT  = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOAD = 2'd1,
    ST_DIV  = 2'd2,
    ST_EMIT = 2'd3
  } state_e;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             step;
    logic             emit;
    logic             last;
    logic [LED_W-1:0] led;
  } cmd_t;

endpackage
`default_nettype wire

### design/coil_drive_status_led_colorizer.sv
// Top level of the coil drive status LED colorizer.
// A new request is taken only in idle: in_stall_o stays high until the last LED of the
// frame has been emitted, and an output stall holds the emit. Each LED takes one operand
// load, 8 steps of the shared radix-2 divider and one emit.
// Reset: asynchronous active low; clears phase, chase head and control, and restores
// led_to_coil_map to 228 and cmd_full_scale to 1000.
`timescale 1ns / 1ps
`default_nettype none
module coil_drive_status_led_colorizer #(
  parameter int LedCount = cdslc_pkg::LED_COUNT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          mode_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0]  coil_cmd_0_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0]  coil_cmd_1_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0]  coil_cmd_2_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0]  coil_cmd_3_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [cdslc_pkg::LED_W-1:0]              led_index_o,
  output logic [cdslc_pkg::COLOR_W-1:0]            red_o,
  output logic [cdslc_pkg::GREEN_W-1:0]            green_o,
  output logic [cdslc_pkg::COLOR_W-1:0]            blue_o,
  output logic                                     frame_end_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [cdslc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [cdslc_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  cdslc_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  cdslc_ctrl #(
    .LedCount (LedCount)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  cdslc_dp #(
    .LedCount (LedCount)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .coil_cmd_0_i (coil_cmd_0_i),
    .coil_cmd_1_i (coil_cmd_1_i),
    .coil_cmd_2_i (coil_cmd_2_i),
    .coil_cmd_3_i (coil_cmd_3_i),
    .led_index_o  (led_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .frame_end_o  (frame_end_o)
  );

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> led_index_o == cdslc_pkg::LED_W'(LedCount - 1))
    else $error("frame end on wrong LED");

  a_color_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_o <= cdslc_pkg::BRIGHT_CAP && blue_o <= cdslc_pkg::BRIGHT_CAP)
    else $error("color above cap");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  a_frame_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> in_stall_o)
    else $error("idle before frame end");

endmodule
`default_nettype wire

### design/cdslc_ctrl.sv
// Controller state machine: sequences LEDs, divider steps and output handshake.
`timescale 1ns / 1ps
`default_nettype none
module cdslc_ctrl #(
  parameter int LedCount = cdslc_pkg::LED_COUNT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output cdslc_pkg::cmd_t      cmd_o
);

  cdslc_pkg::state_e state_q, state_d;
  logic [cdslc_pkg::STEP_W-1:0] step_q, step_d;
  logic [cdslc_pkg::LED_W-1:0]  led_q, led_d;
  logic                         out_valid_q, out_valid_d;
  logic                         last;
  logic                         emit_ok;

  assign last    = (led_q == cdslc_pkg::LED_W'(LedCount - 1));
  assign emit_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cdslc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cdslc_pkg::ST_LOAD;
      end
      cdslc_pkg::ST_LOAD: begin
        state_d = cdslc_pkg::ST_DIV;
      end
      cdslc_pkg::ST_DIV: begin
        if (step_q == cdslc_pkg::STEP_W'(cdslc_pkg::QUO_W - 1)) state_d = cdslc_pkg::ST_EMIT;
      end
      cdslc_pkg::ST_EMIT: begin
        if (emit_ok) state_d = last ? cdslc_pkg::ST_IDLE : cdslc_pkg::ST_LOAD;
      end
      default: state_d = cdslc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != cdslc_pkg::ST_IDLE);
    cmd_o.accept  = (state_q == cdslc_pkg::ST_IDLE) && in_valid_i;
    cmd_o.load    = (state_q == cdslc_pkg::ST_LOAD);
    cmd_o.step    = (state_q == cdslc_pkg::ST_DIV);
    cmd_o.emit    = (state_q == cdslc_pkg::ST_EMIT) && emit_ok;
    cmd_o.last    = last;
    cmd_o.led     = led_q;
    out_valid_o   = out_valid_q;
  end

  always_comb begin
    step_d      = step_q;
    led_d       = led_q;
    out_valid_d = out_valid_q;
    if (cmd_o.load) step_d = '0;
    if (cmd_o.step) step_d = step_q + 1'b1;
    if (cmd_o.accept) led_d = '0;
    if (cmd_o.emit && !last) led_d = led_q + 1'b1;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdslc_pkg::ST_IDLE;
      step_q      <= '0;
      led_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### design/cdslc_dp.sv
// Datapath: config, phase and chase head, shared radix-2 divider, color result register.
`timescale 1ns / 1ps
`default_nettype none
module cdslc_dp #(
  parameter int LedCount = cdslc_pkg::LED_COUNT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire cdslc_pkg::cmd_t                   cmd_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [cdslc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [cdslc_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  wire logic [1:0]                        mode_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0] coil_cmd_0_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0] coil_cmd_1_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0] coil_cmd_2_i,
  input  wire logic signed [cdslc_pkg::CMD_W-1:0] coil_cmd_3_i,
  output logic [cdslc_pkg::LED_W-1:0]            led_index_o,
  output logic [cdslc_pkg::COLOR_W-1:0]          red_o,
  output logic [cdslc_pkg::GREEN_W-1:0]          green_o,
  output logic [cdslc_pkg::COLOR_W-1:0]          blue_o,
  output logic                                   frame_end_o
);

  localparam int CW = cdslc_pkg::COLOR_W;
  localparam int GW = cdslc_pkg::GREEN_W;
  localparam int NW = cdslc_pkg::NUM_W;
  localparam int DW = cdslc_pkg::DSH_W;

  logic [cdslc_pkg::MAP_W-1:0]   map_q;
  logic [cdslc_pkg::FS_W-1:0]    fs_q;
  logic [cdslc_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [cdslc_pkg::LED_W-1:0]   head_q, head_d;
  cdslc_pkg::mode_e              mode_q;
  logic [cdslc_pkg::CMD_W-1:0]   coil_q [cdslc_pkg::LED_COUNT_MAX];

  logic [NW-1:0]                 rem_q, rem_d;
  logic [DW-1:0]                 dsh_q, dsh_d;
  logic [cdslc_pkg::QUO_W-1:0]   quo_q, quo_d;
  logic                          sat_q, sat_d;
  logic                          neg_q, neg_d;
  logic                          zero_q, zero_d;

  logic [CW-1:0]                 red_q, red_d;
  logic [GW-1:0]                 green_q, green_d;
  logic [CW-1:0]                 blue_q, blue_d;
  logic [cdslc_pkg::LED_W-1:0]   led_q;
  logic                          frame_end_q;

  logic [1:0]                    coil_sel;
  logic [cdslc_pkg::CMD_W-1:0]   raw;
  logic [cdslc_pkg::CMD_W-1:0]   mag;
  logic [cdslc_pkg::FS_W-1:0]    fs_eff;
  logic [8:0]                    tri_x;
  logic [7:0]                    tri_t;
  logic [NW-1:0]                 num_run;
  logic [NW-1:0]                 num_idle;
  logic                          ge;
  logic [CW-1:0]                 lvl;

  // Run mode operands
  assign coil_sel = map_q[{cmd_i.led, 1'b0} +: 2];
  assign raw      = coil_q[coil_sel];
  assign mag      = raw[cdslc_pkg::CMD_W-1] ? cdslc_pkg::CMD_W'(-raw) : raw;
  assign fs_eff   = (fs_q == '0) ? cdslc_pkg::FS_W'(1) : fs_q;
  assign num_run  = (NW'(mag) << 7) + (NW'(mag) << 5);

  // Idle mode operands: triangle wave of phase times four
  assign tri_x    = {phase_q[6:0], 2'b00};
  assign tri_t    = tri_x[8] ? 8'(9'h1FF - tri_x) : tri_x[7:0];
  assign num_idle = (NW'(tri_t) << 7) + (NW'(tri_t) << 5);

  assign ge = (rem_q >= NW'(dsh_q));

  always_comb begin
    phase_d = phase_q;
    head_d  = head_q;
    if (cmd_i.accept) begin
      phase_d = phase_q + 1'b1;
      if (phase_d[2:0] == 3'b000) begin
        if (phase_d == '0 || head_q == cdslc_pkg::LED_W'(LedCount - 1)) begin
          head_d = '0;
        end else begin
          head_d = head_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (cmd_i.load) begin
      quo_d = '0;
      if (mode_q == cdslc_pkg::MODE_IDLE) begin
        rem_d  = num_idle;
        dsh_d  = {cdslc_pkg::IDLE_DEN, 7'b0};
        sat_d  = 1'b0;
        neg_d  = 1'b0;
        zero_d = 1'b0;
      end else begin
        rem_d  = num_run;
        dsh_d  = {fs_eff, 7'b0};
        sat_d  = (mag >= cdslc_pkg::CMD_W'(fs_eff));
        neg_d  = raw[cdslc_pkg::CMD_W-1];
        zero_d = (raw == '0);
      end
    end else if (cmd_i.step) begin
      if (ge) rem_d = rem_q - NW'(dsh_q);
      quo_d = {quo_q[cdslc_pkg::QUO_W-2:0], ge};
      dsh_d = dsh_q >> 1;
    end
  end

  assign lvl = sat_q ? cdslc_pkg::BRIGHT_CAP : quo_q;

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    case (mode_q)
      cdslc_pkg::MODE_FAULT: begin
        red_d = phase_q[3] ? cdslc_pkg::BRIGHT_CAP : '0;
      end
      cdslc_pkg::MODE_BOOT: begin
        blue_d = (cmd_i.led == head_q) ? cdslc_pkg::BRIGHT_CAP : cdslc_pkg::CHASE_DIM;
      end
      cdslc_pkg::MODE_IDLE: begin
        red_d   = quo_q;
        green_d = GW'(quo_q >> 1);
      end
      cdslc_pkg::MODE_RUN: begin
        green_d = cdslc_pkg::GREEN_BASE;
        if (!zero_q) begin
          if (neg_q) begin
            red_d = lvl;
          end else begin
            blue_d = lvl;
          end
        end
      end
      default: begin
        red_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= cdslc_pkg::MAP_RESET;
      fs_q    <= cdslc_pkg::FS_RESET;
      phase_q <= '0;
      head_q  <= '0;
    end else begin
      phase_q <= phase_d;
      head_q  <= head_d;
      if (cfg_we_i && cfg_index_i == cdslc_pkg::CFG_LED_MAP) begin
        map_q <= cfg_data_i[cdslc_pkg::MAP_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == cdslc_pkg::CFG_FULL_SCALE) begin
        fs_q <= cfg_data_i[cdslc_pkg::FS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q    <= cdslc_pkg::mode_e'(mode_i);
      coil_q[0] <= coil_cmd_0_i;
      coil_q[1] <= coil_cmd_1_i;
      coil_q[2] <= coil_cmd_2_i;
      coil_q[3] <= coil_cmd_3_i;
    end
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    sat_q  <= sat_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    if (cmd_i.emit) begin
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      led_q       <= cmd_i.led;
      frame_end_q <= cmd_i.last;
    end
  end

  assign led_index_o = led_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign frame_end_o = frame_end_q;

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the coil drive status LED colorizer.
`timescale 1ns / 1ps
module tb_top;
  import cdslc_pkg::*;

  localparam int LEDS = LED_COUNT_DEF;

  typedef struct packed {
    mode_e                 mode;
    logic [3:0][CMD_W-1:0] cmd;
    logic                  drain;
  } tick_req_t;

  typedef struct packed {
    logic [LED_W-1:0]   led;
    logic [COLOR_W-1:0] red;
    logic [GREEN_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } led_color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic signed [CMD_W-1:0] coil_cmd_0_i = '0;
  logic signed [CMD_W-1:0] coil_cmd_1_i = '0;
  logic signed [CMD_W-1:0] coil_cmd_2_i = '0;
  logic signed [CMD_W-1:0] coil_cmd_3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [LED_W-1:0] led_index_o;
  logic [COLOR_W-1:0] red_o;
  logic [GREEN_W-1:0] green_o;
  logic [COLOR_W-1:0] blue_o;
  logic frame_end_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  tick_req_t  tick_q[$];
  led_color_t color_q[$];

  logic [MAP_W-1:0]   map_shadow = MAP_RESET;
  logic [FS_W-1:0]    fs_shadow = FS_RESET;
  logic [PHASE_W-1:0] phase_cnt = '0;

  int gap_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int err_cnt = 0;
  int tick_cnt = 0;
  int color_cnt = 0;
  int wr_cnt = 0;
  int mode_hits[4] = '{0, 0, 0, 0};

  coil_drive_status_led_colorizer #(.LedCount(LEDS)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .coil_cmd_0_i (coil_cmd_0_i),
    .coil_cmd_1_i (coil_cmd_1_i),
    .coil_cmd_2_i (coil_cmd_2_i),
    .coil_cmd_3_i (coil_cmd_3_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .led_index_o  (led_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .frame_end_o  (frame_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void colorize_tick(tick_req_t t);
    led_color_t c;
    int unsigned head;
    int unsigned tri_v;
    int unsigned lvl;
    int unsigned mag;
    int unsigned fs;
    logic [8:0] x;
    logic [1:0] coil;
    logic [CMD_W-1:0] raw;
    phase_cnt = phase_cnt + 1'b1;
    mode_hits[t.mode]++;
    for (int i = 0; i < LEDS; i++) begin
      c = '0;
      c.led = i[LED_W-1:0];
      c.last = (i == LEDS - 1);
      case (t.mode)
        MODE_FAULT: begin
          c.red = phase_cnt[3] ? BRIGHT_CAP : 8'd0;
        end
        MODE_BOOT: begin
          head = (phase_cnt >> 3) % LEDS;
          c.blue = (i == head) ? BRIGHT_CAP : CHASE_DIM;
        end
        MODE_IDLE: begin
          x = {phase_cnt[6:0], 2'b00};
          tri_v = (x < 9'h100) ? x : 9'h1FF - x;
          lvl = tri_v * BRIGHT_CAP / IDLE_DEN;
          c.red = lvl[COLOR_W-1:0];
          c.green = lvl[GREEN_W:1];
        end
        default: begin
          coil = map_shadow[2*i +: 2];
          raw = t.cmd[coil];
          mag = raw[CMD_W-1] ? 32'h10000 - raw : raw;
          fs = (fs_shadow == 0) ? 1 : fs_shadow;
          lvl = mag * BRIGHT_CAP / fs;
          if (lvl > BRIGHT_CAP) lvl = BRIGHT_CAP;
          c.green = GREEN_BASE;
          if (raw != 0) begin
            if (raw[CMD_W-1]) c.red = lvl[COLOR_W-1:0];
            else c.blue = lvl[COLOR_W-1:0];
          end
        end
      endcase
      color_q.push_back(c);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : drive_proc
    logic fire;
    logic hold;
    logic nxt_valid;
    if (rst_ni) begin
      fire = in_valid_i && !in_stall_o;
      hold = in_valid_i && !fire;
      nxt_valid = hold;
      if (fire) begin
        colorize_tick(tick_q[0]);
        tick_q.delete(0);
        tick_cnt++;
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_q.size() > 0 && !(tick_q[0].drain && color_q.size() > 0)) begin
          if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 13) - 1;
          else nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
      if (nxt_valid && !hold) begin
        mode_i <= tick_q[0].mode;
        coil_cmd_0_i <= tick_q[0].cmd[0];
        coil_cmd_1_i <= tick_q[0].cmd[1];
        coil_cmd_2_i <= tick_q[0].cmd[2];
        coil_cmd_3_i <= tick_q[0].cmd[3];
      end
    end
  end

  always @(posedge clk_i) begin : mon_proc
    led_color_t want;
    logic nxt_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (color_q.size() == 0) begin
          $error("unexpected color for led %0d", led_index_o);
          err_cnt++;
        end else begin
          want = color_q.pop_front();
          check_field("led_index", want.led, led_index_o);
          check_field("red", want.red, red_o);
          check_field("green", want.green, green_o);
          check_field("blue", want.blue, blue_o);
          check_field("frame_end", want.last, frame_end_o);
          color_cnt++;
        end
      end
      if (long_hold_req && !long_hold_done) begin
        stall_left = 500;
        long_hold_done = 1'b1;
      end
      nxt_stall = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        nxt_stall = 1'b1;
      end
      out_stall_i <= nxt_stall;
    end
  end

  function automatic logic [CMD_W-1:0] rand_cmd();
    int v;
    case ($urandom_range(0, 5))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      2, 3: begin
        v = $urandom_range(0, 2 * fs_shadow + 1);
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 1)) v = -v;
        return v[CMD_W-1:0];
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tick_req_t rand_tick();
    tick_req_t t;
    int r;
    r = $urandom_range(0, 6);
    t.mode = (r < 4) ? MODE_RUN : mode_e'(r - 3);
    for (int i = 0; i < 4; i++) t.cmd[i] = rand_cmd();
    t.drain = ($urandom_range(0, 24) == 0);
    return t;
  endfunction

  task automatic queue_tick(mode_e m, int c0, int c1, int c2, int c3, bit drain = 1'b0);
    tick_req_t t;
    t.mode = m;
    t.cmd[0] = c0[CMD_W-1:0];
    t.cmd[1] = c1[CMD_W-1:0];
    t.cmd[2] = c2[CMD_W-1:0];
    t.cmd[3] = c3[CMD_W-1:0];
    t.drain = drain;
    tick_q.push_back(t);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || color_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_LED_MAP) map_shadow = val[MAP_W-1:0];
    else if (idx == CFG_FULL_SCALE) fs_shadow = val[FS_W-1:0];
    wr_cnt++;
  endtask

  initial begin : stim_proc
    logic [MAP_W-1:0] maps[5];
    logic [CFG_DAT_W-1:0] scales[5];
    int counts[5];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: identity map, full scale 1000
    queue_tick(MODE_RUN, 0, 0, 0, 0);
    queue_tick(MODE_RUN, 1, -1, 1000, -1000);
    queue_tick(MODE_RUN, 32767, -32768, 999, -999);
    queue_tick(MODE_RUN, 500, -500, 2000, -7);
    queue_tick(MODE_FAULT, 0, 0, 0, 0);
    queue_tick(MODE_BOOT, 0, 0, 0, 0);
    queue_tick(MODE_IDLE, 0, 0, 0, 0);
    queue_tick(MODE_FAULT, -1, -1, -1, -1);
    queue_tick(MODE_BOOT, 32767, 0, 0, 0);
    queue_tick(MODE_IDLE, -32768, 0, 0, 0);
    queue_tick(MODE_RUN, 123, -4567, 32000, -1, 1'b1);
    wait_drained();

    // reversed map with zero full scale, then writes to unused indexes
    write_reg(CFG_LED_MAP, 16'h001B);
    write_reg(CFG_FULL_SCALE, 16'h0000);
    queue_tick(MODE_RUN, 0, 1, -1, -32768);
    queue_tick(MODE_RUN, 5, 0, 32767, -2);
    wait_drained();
    write_reg(CFG_FULL_SCALE + 1'b1, 16'hFFFF);
    write_reg('1, 16'h1234);
    queue_tick(MODE_RUN, 3, -3, 0, 1);
    queue_tick(MODE_FAULT, 0, 0, 0, 0);
    wait_drained();

    maps = '{8'($urandom), 8'hFF, 8'h00, 8'($urandom), MAP_RESET};
    scales = '{16'h0001, 16'hFFFF, 16'd255, 16'($urandom_range(1, 32767)), 16'(FS_RESET)};
    counts = '{60, 60, 50, 50, 35};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_LED_MAP, maps[ph]);
      write_reg(CFG_FULL_SCALE, scales[ph]);
      if (ph == 4) quiet = 1'b1;
      for (int n = 0; n < counts[ph]; n++) tick_q.push_back(rand_tick());
      if (ph == 1) begin
        repeat (200) @(posedge clk_i);
        long_hold_req = 1'b1;
      end
      wait_drained();
    end

    $display("covered %0d ticks (run %0d, fault %0d, boot %0d, idle %0d), %0d colors checked",
             tick_cnt, mode_hits[MODE_RUN], mode_hits[MODE_FAULT], mode_hits[MODE_BOOT],
             mode_hits[MODE_IDLE], color_cnt);
    $display("%0d register writes incl. zero full scale, max full scale and unused indexes",
             wr_cnt);
    if (err_cnt == 0 && color_q.size() == 0) begin
      $display("coil_drive_status_led_colorizer: match");
    end else begin
      $display("coil_drive_status_led_colorizer: mismatch");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #5000000;
    $display("coil_drive_status_led_colorizer: mismatch");
    $finish;
  end

endmodule
